[rtl/lifo_pkg.sv]
// lifo_pkg: shared constants, operation and status codes and the
// command/status structs of the lifo stack core
// no dependencies
package lifo_pkg;

   localparam int LIFO_DEPTH_DEF = 64;
   localparam int DATA_W         = 32;
   localparam int MODE_W         = 3;
   localparam int OFFS_W         = 6;
   localparam int STAT_W         = 2;

   localparam logic [MODE_W-1:0] MODE_PUSH = 3'd0;
   localparam logic [MODE_W-1:0] MODE_POP  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_PEEK = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TOP  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DUMP = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [STAT_W-1:0] ST_BADPEEK   = 2'd3;

   typedef struct packed {
      logic              push;
      logic              pop;
      logic              peek_rd;
      logic              top_rd;
      logic              dump;
      logic              emit;
      logic [STAT_W-1:0] emit_status;
      logic              fetch_load;
   } lifo_cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic bad_peek;
      logic out_free;
      logic rem_one;
   } lifo_stat_type;

endpackage

[rtl/lifo_ram.sv]
// lifo_ram: generic single-write, single-read ram with registered read
// no dependencies
module lifo_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lifo_ctrl.sv]
// lifo_ctrl: controller state machine, decodes operations into datapath commands
// depends on lifo_pkg
module lifo_ctrl import lifo_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic [MODE_W-1:0] req_mode,
   input  lifo_stat_type     stat,
   output logic              req_tready,
   output lifo_cmd_type      cmd
);

   localparam logic S_IDLE  = 1'b0;
   localparam logic S_FETCH = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = stat.out_free;
            if (req_tvalid && stat.out_free) begin
               unique case (req_mode)
                  MODE_PUSH: begin
                     cmd.emit = 1'b1;
                     if (stat.full) begin
                        cmd.emit_status = ST_OVERFLOW;
                     end else begin
                        cmd.push        = 1'b1;
                        cmd.emit_status = ST_OK;
                     end
                  end
                  MODE_POP: begin
                     if (stat.empty) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_UNDERFLOW;
                     end else begin
                        cmd.pop  = 1'b1;
                        state_in = S_FETCH;
                     end
                  end
                  MODE_PEEK: begin
                     if (stat.bad_peek) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_BADPEEK;
                     end else begin
                        cmd.peek_rd = 1'b1;
                        state_in    = S_FETCH;
                     end
                  end
                  MODE_TOP: begin
                     if (stat.empty) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_UNDERFLOW;
                     end else begin
                        cmd.top_rd = 1'b1;
                        state_in   = S_FETCH;
                     end
                  end
                  MODE_DUMP: begin
                     if (stat.empty) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_UNDERFLOW;
                     end else begin
                        cmd.dump = 1'b1;
                        state_in = S_FETCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_FETCH: begin
            if (stat.out_free) begin
               cmd.fetch_load = 1'b1;
               if (stat.rem_one) begin
                  state_in = S_IDLE;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/lifo_dp.sv]
// lifo_dp: datapath with fill count, read pointer, entry ram and output register
// depends on lifo_pkg and lifo_ram
module lifo_dp import lifo_pkg::*; #(
   parameter int DEPTH = LIFO_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lifo_cmd_type             cmd,
   input  logic signed [DATA_W-1:0] req_push_value,
   input  logic [OFFS_W-1:0]        req_peek_offset,
   input  logic                     rsp_tready,
   output lifo_stat_type            stat,
   output logic                     rsp_tvalid,
   output logic [STAT_W-1:0]        rsp_status,
   output logic signed [DATA_W-1:0] rsp_value,
   output logic                     rsp_last
);

   localparam int CW   = $clog2(DEPTH + 1);
   localparam int AW   = $clog2(DEPTH);
   localparam int CMPW = (CW > OFFS_W) ? CW : OFFS_W;

   logic [CW-1:0]            count_ff, count_in;
   logic [CW-1:0]            rem_ff, rem_in;
   logic [AW-1:0]            ptr_ff, ptr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        status_ff, status_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic                     last_ff, last_in;

   logic [CW-1:0]   cnt_m1;
   logic [CMPW-1:0] peek_diff;
   logic [AW-1:0]   top_addr;
   logic [AW-1:0]   peek_addr;
   logic            fetch_step;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   logic [DATA_W-1:0] rd_data;

   assign cnt_m1    = count_ff - CW'(1);
   assign top_addr  = cnt_m1[AW-1:0];
   assign peek_diff = CMPW'(cnt_m1) - CMPW'(req_peek_offset);
   assign peek_addr = peek_diff[AW-1:0];

   assign stat.full     = (count_ff == CW'(DEPTH));
   assign stat.empty    = (count_ff == '0);
   assign stat.bad_peek = (CMPW'(req_peek_offset) >= CMPW'(count_ff));
   assign stat.out_free = !rsp_valid_ff || rsp_tready;
   assign stat.rem_one  = (rem_ff == CW'(1));

   assign fetch_step = cmd.fetch_load && !stat.rem_one;
   assign rd_en      = cmd.pop || cmd.peek_rd || cmd.top_rd || cmd.dump || fetch_step;

   always_comb begin
      if (cmd.peek_rd) begin
         rd_addr = peek_addr;
      end else if (fetch_step) begin
         rd_addr = ptr_ff - AW'(1);
      end else begin
         rd_addr = top_addr;
      end
   end

   lifo_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_push_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop) begin
         count_in = cnt_m1;
      end

      rem_in = rem_ff;
      ptr_in = ptr_ff;
      if (cmd.dump) begin
         rem_in = count_ff;
         ptr_in = top_addr;
      end else if (cmd.pop || cmd.peek_rd || cmd.top_rd) begin
         rem_in = CW'(1);
         ptr_in = top_addr;
      end else if (fetch_step) begin
         rem_in = rem_ff - CW'(1);
         ptr_in = ptr_ff - AW'(1);
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      status_in    = status_ff;
      value_in     = value_ff;
      last_in      = last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         status_in    = cmd.emit_status;
         value_in     = '0;
         last_in      = 1'b1;
      end else if (cmd.fetch_load) begin
         rsp_valid_in = 1'b1;
         status_in    = ST_OK;
         value_in     = rd_data;
         last_in      = stat.rem_one;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      ptr_ff    <= ptr_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      last_ff   <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_value  = value_ff;
   assign rsp_last   = last_ff;

endmodule

[rtl/lifo_stack_with_peek_core.sv]
// lifo_stack_with_peek_core: top level of the bounded lifo stack with peek and dump
// depends on lifo_pkg, lifo_ctrl, lifo_dp and lifo_ram
//
// channel  | dir | tdata                                | tuser       | tlast
// req      | in  | push_value[31:0] peek_offset[37:32]  | mode[2:0]   | -
// rsp      | out | read_value[31:0]                     | status[1:0] | last_of_run
//
// push and any error result: word ready in the cycle after accept
// pop, peek, top: one ram read, registered, then loaded into the output register
// dump of n entries: a word per cycle unless stalled; ram read overlaps output
// a new request is taken only after the previous request's last word is loaded
// output stalls hold the sequencer; synchronous active-high reset empties the stack
module lifo_stack_with_peek_core import lifo_pkg::*; #(
   parameter int DEPTH = LIFO_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // push_value[31:0], peek_offset[37:32], zero pad
   input  logic [2:0]  req_tuser,   // mode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // read_value[31:0]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast
);

   lifo_cmd_type             cmd;
   lifo_stat_type            stat;
   logic signed [DATA_W-1:0] rsp_value;

   lifo_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser),
      .stat       (stat),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   lifo_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_push_value  (req_tdata[31:0]),
      .req_peek_offset (req_tdata[37:32]),
      .rsp_tready      (rsp_tready),
      .stat            (stat),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_status      (rsp_tuser),
      .rsp_value       (rsp_value),
      .rsp_last        (rsp_tlast)
   );

   assign rsp_tdata = rsp_value;

`ifndef SYNTH
   a_mid_dump_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == ST_OK)
      else $error("non-final word without ok status");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_OK |-> rsp_tdata == '0)
      else $error("error word carries nonzero data");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == MODE_PUSH && !stat.full
      |=> !stat.empty)
      else $error("stack empty after accepted push");
`endif

endmodule

[tb/lifo_stack_with_peek_core_tb.sv]
// lifo_stack_with_peek_core_tb: self-checking bench for the lifo stack core, with a
// scoreboard class that tracks the stack contents and the words each request should return
// depends on lifo_pkg and lifo_stack_with_peek_core
`timescale 1ns / 100ps

module lifo_stack_with_peek_core_tb;
   import lifo_pkg::*;

   localparam int DEPTH       = LIFO_DEPTH_DEF;
   localparam int IDLE_LIMIT  = 4000;
   localparam int TAIL_CYCLES = 20;
   localparam int PHASE_ITEMS = 100;

   class lifo_scoreboard;
      typedef struct {
         logic [STAT_W-1:0] status;
         logic [DATA_W-1:0] value;
         logic              last;
      } rsp_word_type;

      logic [DATA_W-1:0] stack_mem [64];
      int unsigned       fill;
      int unsigned       cap;
      rsp_word_type      pending_words [$];
      int                errors;
      int                requests;
      int                words_checked;
      int                status_seen [4];

      function new(int unsigned depth);
         cap = depth;
         fill = 0;
         errors = 0;
         requests = 0;
         words_checked = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void add_word(logic [STAT_W-1:0] st, logic [DATA_W-1:0] val, logic last);
         rsp_word_type w;
         w.status = st;
         w.value  = val;
         w.last   = last;
         pending_words.push_back(w);
      endfunction

      function int pending();
         return pending_words.size();
      endfunction

      // predicts the words caused by one accepted request
      function void note_request(logic [MODE_W-1:0] mode, logic [DATA_W-1:0] value,
                                 logic [OFFS_W-1:0] offs);
         requests++;
         case (mode)
            MODE_PUSH: begin
               if (fill >= cap) begin
                  add_word(ST_OVERFLOW, '0, 1'b1);
               end else begin
                  stack_mem[fill] = value;
                  fill++;
                  add_word(ST_OK, '0, 1'b1);
               end
            end
            MODE_POP: begin
               if (fill == 0) begin
                  add_word(ST_UNDERFLOW, '0, 1'b1);
               end else begin
                  fill--;
                  add_word(ST_OK, stack_mem[fill], 1'b1);
               end
            end
            MODE_PEEK: begin
               if (offs >= fill) add_word(ST_BADPEEK, '0, 1'b1);
               else add_word(ST_OK, stack_mem[fill - 1 - offs], 1'b1);
            end
            MODE_TOP: begin
               if (fill == 0) add_word(ST_UNDERFLOW, '0, 1'b1);
               else add_word(ST_OK, stack_mem[fill - 1], 1'b1);
            end
            MODE_DUMP: begin
               if (fill == 0) begin
                  add_word(ST_UNDERFLOW, '0, 1'b1);
               end else begin
                  for (int i = 0; i < fill; i++)
                     add_word(ST_OK, stack_mem[fill - 1 - i], (i == fill - 1));
               end
            end
            default: ;
         endcase
      endfunction

      function void check_word(logic [STAT_W-1:0] st, logic [DATA_W-1:0] val, logic last);
         rsp_word_type w;
         if (pending_words.size() == 0) begin
            $error("unexpected word: status %0d, read_value %h, last_of_run %0d",
                   st, val, last);
            errors++;
            return;
         end
         w = pending_words.pop_front();
         words_checked++;
         status_seen[st]++;
         if (st !== w.status) begin
            $error("status mismatch: expected %0d, actual %0d", w.status, st);
            errors++;
         end
         if (val !== w.value) begin
            $error("read_value mismatch: expected %h, actual %h", w.value, val);
            errors++;
         end
         if (last !== w.last) begin
            $error("last_of_run mismatch: expected %0d, actual %0d", w.last, last);
            errors++;
         end
      endfunction

      function void flush_leftover();
         if (pending_words.size() != 0) begin
            $error("%0d expected words never arrived", pending_words.size());
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // push_value[31:0], peek_offset[37:32], zero pad
   logic [2:0]  req_tuser;   // mode[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // read_value[31:0]
   logic [1:0]  rsp_tuser;   // status[1:0]
   logic        rsp_tlast;

   lifo_scoreboard sb;
   int             send_idle_pct;
   int             rsp_stall_pct;
   int             level;
   bit             growing;
   int             idle_cycles;

   lifo_stack_with_peek_core #(.DEPTH(DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // check before note: a word at the output never belongs to a request taken this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_word(rsp_tuser, rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[31:0], req_tdata[37:32]);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int draw_gap(int pct);
      int n;
      n = 0;
      while ($urandom_range(99) < pct) n++;
      return n;
   endfunction

   function automatic logic [31:0] pick_value();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom();
      endcase
   endfunction

   // returns at the edge where the word is taken; tvalid stays high for the next one
   task automatic send_word(input logic [2:0] mode, input logic [31:0] value,
                            input logic [5:0] offs);
      int gap;
      gap = draw_gap(send_idle_pct);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, offs, value};
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      case (mode)
         MODE_PUSH: if (level < DEPTH) level++;
         MODE_POP:  if (level > 0) level--;
         default: ;
      endcase
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic run_random(input int count);
      int          done;
      int          roll;
      logic [2:0]  mode;
      logic [5:0]  offs;
      done = 0;
      while (done < count) begin
         roll = $urandom_range(99);
         offs = 6'($urandom_range(63));
         if (roll < 6) begin
            mode = 3'($urandom_range(7));
         end else if (roll < 10) begin
            mode = MODE_DUMP;
         end else if (roll < 22) begin
            mode = MODE_PEEK;
            if (level > 0 && $urandom_range(3) != 0)
               offs = 6'($urandom_range(level - 1));
         end else if (roll < 30) begin
            mode = MODE_TOP;
         end else if (roll < 90) begin
            mode = growing ? MODE_PUSH : MODE_POP;
         end else begin
            mode = growing ? MODE_POP : MODE_PUSH;
         end
         if (mode <= MODE_DUMP) done++;
         send_word(mode, pick_value(), offs);
         if (growing && level == DEPTH && $urandom_range(3) == 0) growing = 1'b0;
         else if (!growing && level == 0 && $urandom_range(3) == 0) growing = 1'b1;
      end
   endtask

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      rsp_tready    = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      level         = 0;
      growing       = 1'b1;
      idle_cycles   = 0;
      sb = new(DEPTH);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty stack corners
      send_word(MODE_POP,  32'h0, 6'd0);
      send_word(MODE_TOP,  32'h0, 6'd0);
      send_word(MODE_DUMP, 32'h0, 6'd0);
      send_word(MODE_PEEK, 32'h0, 6'd0);
      // extreme words
      send_word(MODE_PUSH, 32'h7fff_ffff, 6'd0);
      send_word(MODE_PUSH, 32'h8000_0000, 6'd63);
      send_word(MODE_PUSH, 32'h0000_0000, 6'd0);
      send_word(MODE_PUSH, 32'hffff_ffff, 6'd21);
      send_word(MODE_TOP,  32'h0, 6'd0);
      send_word(MODE_PEEK, 32'h0, 6'd0);
      send_word(MODE_PEEK, 32'h0, 6'd3);
      send_word(MODE_PEEK, 32'h0, 6'd4);
      send_word(MODE_PEEK, 32'h0, 6'd63);
      send_word(MODE_DUMP, 32'h0, 6'd0);
      // unused modes cause nothing
      send_word(3'd5, $urandom(), 6'($urandom_range(63)));
      send_word(3'd6, $urandom(), 6'($urandom_range(63)));
      send_word(3'd7, $urandom(), 6'($urandom_range(63)));
      send_word(MODE_POP,  32'h0, 6'd0);
      send_word(MODE_PUSH, 32'h5555_5555, 6'd42);
      repeat (5) send_word(MODE_POP, 32'h0, 6'd0);
      drain_results();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 49; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 49; end
            default: begin send_idle_pct = 27; rsp_stall_pct = 27; end
         endcase
         run_random(PHASE_ITEMS);
         drain_results();
      end

      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      sb.flush_leftover();

      $display("summary: %0d requests, %0d words checked (ok %0d, overflow %0d,",
               sb.requests, sb.words_checked, sb.status_seen[ST_OK],
               sb.status_seen[ST_OVERFLOW]);
      $display("summary: underflow %0d, bad peek %0d) over four flow-control phases",
               sb.status_seen[ST_UNDERFLOW], sb.status_seen[ST_BADPEEK]);
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
